[design/pfa_pkg.sv]
// ----------------------------------------------------------------------------
// Page frame allocator package
// Shared sizes, operation and status codes and the controller state type.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int REF_BITS  = 16;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int DEPTH_W   = $clog2(MAX_PAGES + 1);
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  // A count word holds the reference count above a free flag in bit 0.
  localparam int CNT_WORD_W = REF_BITS + 1;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_ALLOC  = 3'd1,
    MODE_FREE   = 3'd2,
    MODE_INCREF = 3'd3,
    MODE_DECREF = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOMEM   = 3'd1,
    ST_BADFREE = 3'd2,
    ST_DECZERO = 3'd3,
    ST_RANGE   = 3'd4,
    ST_SAT     = 3'd5
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PAGE_COUNT = 1'd0,
    CFG_RESERVED   = 1'd1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_INIT    = 5'b00010,
    S_INIT_WB = 5'b00100,
    S_POP     = 5'b01000,
    S_RMW     = 5'b10000
  } state_t;

endpackage

[design/pfa_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/page_frame_allocator_refcount_unit.sv]
// ----------------------------------------------------------------------------
// Page frame allocator with reference counts
// A LIFO free stack and a per-page count memory, driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage: raise start with in_mode and in_page_index while busy is low; the
// item is taken at that edge. Every item gives exactly one result, shown for
// one cycle with out_valid high. The receiver cannot stall, so results are
// never held back; a new item may be started in the same cycle as the
// result of the previous one is shown.
// Timing is set by the registered read data of the two memories:
// - alloc with an empty stack, out-of-range pages and unknown modes: the
//   result is registered and shown in the cycle after acceptance;
// - free, incref and decref: one count read-modify-write in S_RMW;
// - alloc: a stack read (S_POP) followed by a count read-modify-write (S_RMW);
// - init: managed pages pass through S_INIT, unmanaged ones through S_INIT
//   and S_INIT_WB, over all 1024 pages, then the result.
// Configuration (page_count, reserved_pages) is written through the cfg_
// channel, which is always ready, and must only change while idle.
// After reset the stack is empty and the registers hold their defaults; an
// init item must run before pages are freed, referenced or dereferenced.
// ----------------------------------------------------------------------------
module page_frame_allocator_refcount_unit
  import pfa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           in_mode,
  input  logic [PAGE_W-1:0]    in_page_index,
  output logic                 out_valid,
  output logic [PAGE_W-1:0]    out_result_page,
  output logic [2:0]           out_status,
  output logic [REF_BITS-1:0]  out_ref_count,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [PAGE_W-1:0]   page_r, page_nxt;
  logic [PAGE_W-1:0]   idx_r, idx_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [CFG_W-1:0]    page_count_r, reserved_r;

  logic                out_valid_r, out_valid_nxt;
  logic [PAGE_W-1:0]   out_page_r, out_page_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [REF_BITS-1:0] out_count_r, out_count_nxt;

  logic                  cnt_we;
  logic [PAGE_W-1:0]     cnt_waddr, cnt_raddr;
  logic [CNT_WORD_W-1:0] cnt_wdata, cnt_rdata;
  logic                  stk_we;
  logic [PAGE_W-1:0]     stk_waddr, stk_raddr, stk_wdata, stk_rdata;

  logic [CFG_W-1:0]    managed;
  logic                stack_full;
  logic                idx_managed;
  logic                idx_last;
  logic [REF_BITS-1:0] rd_count;
  logic                rd_free;
  logic [REF_BITS-1:0] dec_count;
  logic                dec_push;

  pfa_ram #(.WIDTH(CNT_WORD_W), .DEPTH(MAX_PAGES)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  pfa_ram #(.WIDTH(PAGE_W), .DEPTH(MAX_PAGES)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  assign managed     = (page_count_r > CFG_W'(MAX_PAGES)) ? CFG_W'(MAX_PAGES) : page_count_r;
  assign stack_full  = (depth_r == DEPTH_W'(MAX_PAGES));
  assign idx_managed = (CFG_W'(idx_r) < managed);
  assign idx_last    = (idx_r == PAGE_W'(MAX_PAGES - 1));
  assign rd_count    = cnt_rdata[CNT_WORD_W-1:1];
  assign rd_free     = cnt_rdata[0];
  assign dec_count   = rd_count - REF_BITS'(1);
  assign dec_push    = (dec_count == '0) && !rd_free && !stack_full;

  assign busy            = (state_r != S_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_result_page = out_page_r;
  assign out_status      = out_status_r;
  assign out_ref_count   = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    page_nxt       = page_r;
    idx_nxt        = idx_r;
    depth_nxt      = depth_r;
    out_valid_nxt  = 1'b0;
    out_page_nxt   = out_page_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    cnt_we         = 1'b0;
    cnt_waddr      = page_r;
    cnt_wdata      = cnt_rdata;
    cnt_raddr      = in_page_index;
    stk_we         = 1'b0;
    stk_waddr      = depth_r[PAGE_W-1:0];
    stk_wdata      = page_r;
    stk_raddr      = PAGE_W'(depth_r - DEPTH_W'(1));

    case (state_r)
      S_IDLE: begin
        if (start) begin
          page_nxt = in_page_index;
          case (in_mode)
            MODE_INIT: begin
              mode_nxt  = MODE_INIT;
              depth_nxt = '0;
              idx_nxt   = '0;
              state_nxt = S_INIT;
            end
            MODE_ALLOC: begin
              mode_nxt = MODE_ALLOC;
              if (depth_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_page_nxt   = '0;
                out_status_nxt = ST_NOMEM;
                out_count_nxt  = '0;
              end else begin
                depth_nxt = depth_r - DEPTH_W'(1);
                state_nxt = S_POP;
              end
            end
            MODE_FREE, MODE_INCREF, MODE_DECREF: begin
              mode_nxt = mode_t'(in_mode);
              if (CFG_W'(in_page_index) >= managed) begin
                out_valid_nxt  = 1'b1;
                out_page_nxt   = in_page_index;
                out_status_nxt = ST_RANGE;
                out_count_nxt  = '0;
              end else begin
                state_nxt = S_RMW;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_page_nxt   = in_page_index;
              out_status_nxt = ST_OK;
              out_count_nxt  = '0;
            end
          endcase
        end
      end

      S_INIT: begin
        cnt_raddr = idx_r;
        if (idx_managed) begin
          cnt_we    = 1'b1;
          cnt_waddr = idx_r;
          if (CFG_W'(idx_r) < reserved_r) begin
            cnt_wdata = {REF_BITS'(1), 1'b0};
          end else begin
            // Page goes onto the stack in ascending order.
            cnt_wdata = {REF_BITS'(0), 1'b1};
            stk_we    = 1'b1;
            stk_wdata = idx_r;
            depth_nxt = depth_r + DEPTH_W'(1);
          end
          if (idx_last) begin
            out_valid_nxt  = 1'b1;
            out_page_nxt   = page_r;
            out_status_nxt = ST_OK;
            out_count_nxt  = '0;
            state_nxt      = S_IDLE;
          end else begin
            idx_nxt = idx_r + PAGE_W'(1);
          end
        end else begin
          // Unmanaged page keeps its count; only the free flag is cleared.
          state_nxt = S_INIT_WB;
        end
      end

      S_INIT_WB: begin
        cnt_we    = 1'b1;
        cnt_waddr = idx_r;
        cnt_wdata = {rd_count, 1'b0};
        if (idx_last) begin
          out_valid_nxt  = 1'b1;
          out_page_nxt   = page_r;
          out_status_nxt = ST_OK;
          out_count_nxt  = '0;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt   = idx_r + PAGE_W'(1);
          state_nxt = S_INIT;
        end
      end

      S_POP: begin
        page_nxt  = stk_rdata;
        cnt_raddr = stk_rdata;
        state_nxt = S_RMW;
      end

      S_RMW: begin
        out_valid_nxt  = 1'b1;
        out_page_nxt   = page_r;
        out_status_nxt = ST_OK;
        out_count_nxt  = rd_count;
        state_nxt      = S_IDLE;
        case (mode_r)
          MODE_ALLOC: begin
            cnt_we    = 1'b1;
            cnt_wdata = {rd_count, 1'b0};
          end
          MODE_FREE: begin
            if ((rd_count != '0) || rd_free || stack_full) begin
              out_status_nxt = ST_BADFREE;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = {rd_count, 1'b1};
              stk_we    = 1'b1;
              depth_nxt = depth_r + DEPTH_W'(1);
            end
          end
          MODE_INCREF: begin
            if (rd_count == '1) begin
              out_status_nxt = ST_SAT;
            end else begin
              cnt_we        = 1'b1;
              cnt_wdata     = {rd_count + REF_BITS'(1), rd_free};
              out_count_nxt = rd_count + REF_BITS'(1);
            end
          end
          MODE_DECREF: begin
            if (rd_count == '0) begin
              out_status_nxt = ST_DECZERO;
              out_count_nxt  = '0;
            end else begin
              cnt_we        = 1'b1;
              cnt_wdata     = {dec_count, rd_free | dec_push};
              out_count_nxt = dec_count;
              if (dec_push) begin
                stk_we    = 1'b1;
                depth_nxt = depth_r + DEPTH_W'(1);
              end
            end
          end
          default: begin
            out_count_nxt = '0;
          end
        endcase
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      depth_r      <= '0;
      out_valid_r  <= 1'b0;
      page_count_r <= CFG_W'(MAX_PAGES);
      reserved_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PAGE_COUNT: page_count_r <= cfg_data;
          CFG_RESERVED:   reserved_r   <= cfg_data;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    page_r       <= page_nxt;
    idx_r        <= idx_nxt;
    out_page_r   <= out_page_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

endmodule
